// ===== src/futd_pkg.sv =====
// ----------------------------------------------------------------------------
// futd_pkg
// Shared types and constants for the font Unicode table decoder.
// ----------------------------------------------------------------------------
package futd_pkg;

	localparam int DEF_INDEX_BITS = 16;

	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 16;
	localparam int GLYPH_W   = 17;
	localparam int CODE_W    = 31;
	localparam int LEFT_W    = 3;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BASE  = 2'd1;

	// Special byte values of the table.
	localparam logic [BYTE_W-1:0] BYTE_ENTRY_END = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_TILDE_SRC = 8'hFE;
	localparam logic [BYTE_W-1:0] CODE_TILDE     = 8'h7E;
	localparam logic [BYTE_W-1:0] LEAD_MIN       = 8'hC0;
	localparam logic [1:0]        CONT_TAG       = 2'b10;

	typedef struct packed {
		logic [GLYPH_W-1:0] entry_number;
		logic [CODE_W-1:0]  partial_code;
		logic [LEFT_W-1:0]  bytes_left;
	} dec_state_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph_index;
		logic [CODE_W-1:0]  code_point;
	} result_t;

endpackage

// ===== src/futd_step.sv =====
// ----------------------------------------------------------------------------
// futd_step
// Decodes one table byte against the running state: next state and result.
// ----------------------------------------------------------------------------
module futd_step #(
	parameter int INDEX_BITS = futd_pkg::DEF_INDEX_BITS
) (
	input  futd_pkg::dec_state_t            state,
	input  logic [futd_pkg::BYTE_W-1:0]     in_byte,
	input  logic [futd_pkg::COUNT_W-1:0]    glyph_count,
	input  logic [futd_pkg::COUNT_W-1:0]    index_base,
	output futd_pkg::dec_state_t            state_next,
	output logic                            res_valid,
	output futd_pkg::result_t               res
);

	localparam int KeepBits = (INDEX_BITS + 1 < futd_pkg::GLYPH_W) ?
		INDEX_BITS + 1 : futd_pkg::GLYPH_W;
	localparam logic [futd_pkg::GLYPH_W-1:0] IdxMask =
		futd_pkg::GLYPH_W'((64'd1 << KeepBits) - 64'd1);

	logic                           active;
	logic [futd_pkg::GLYPH_W-1:0]   idx_sum;
	logic [futd_pkg::CODE_W-1:0]    shifted;
	logic [futd_pkg::LEFT_W-1:0]    left_dec;

	assign active   = state.entry_number < {1'b0, glyph_count};
	assign idx_sum  = futd_pkg::GLYPH_W'({1'b0, index_base} + state.entry_number);
	assign shifted  = {state.partial_code[futd_pkg::CODE_W-7:0], in_byte[5:0]};
	assign left_dec = state.bytes_left - futd_pkg::LEFT_W'(1);

	always_comb begin
		state_next      = state;
		res_valid       = 1'b0;
		res.glyph_index = idx_sum & IdxMask;
		res.code_point  = '0;
		if (active) begin
			if (state.bytes_left == '0) begin
				if (in_byte == futd_pkg::BYTE_ENTRY_END) begin
					state_next.entry_number = state.entry_number + futd_pkg::GLYPH_W'(1);
					state_next.partial_code = '0;
				end else if (in_byte < futd_pkg::LEAD_MIN) begin
					res_valid      = 1'b1;
					res.code_point = futd_pkg::CODE_W'(in_byte);
				end else if (in_byte == futd_pkg::BYTE_TILDE_SRC) begin
					res_valid      = 1'b1;
					res.code_point = futd_pkg::CODE_W'(futd_pkg::CODE_TILDE);
				end else begin
					// Lead byte: the run of leading ones sets the sequence length.
					case (in_byte) inside
						[8'hC0:8'hDF]: begin
							state_next.partial_code = futd_pkg::CODE_W'(in_byte[4:0]);
							state_next.bytes_left   = 3'd1;
						end
						[8'hE0:8'hEF]: begin
							state_next.partial_code = futd_pkg::CODE_W'(in_byte[3:0]);
							state_next.bytes_left   = 3'd2;
						end
						[8'hF0:8'hF7]: begin
							state_next.partial_code = futd_pkg::CODE_W'(in_byte[2:0]);
							state_next.bytes_left   = 3'd3;
						end
						[8'hF8:8'hFB]: begin
							state_next.partial_code = futd_pkg::CODE_W'(in_byte[1:0]);
							state_next.bytes_left   = 3'd4;
						end
						default: begin
							state_next.partial_code = futd_pkg::CODE_W'(in_byte[0]);
							state_next.bytes_left   = 3'd5;
						end
					endcase
				end
			end else if (in_byte == futd_pkg::BYTE_ENTRY_END ||
			             in_byte[7:6] != futd_pkg::CONT_TAG) begin
				// A broken sequence is dropped and closes the entry.
				state_next.entry_number = state.entry_number + futd_pkg::GLYPH_W'(1);
				state_next.partial_code = '0;
				state_next.bytes_left   = '0;
			end else begin
				state_next.bytes_left = left_dec;
				if (left_dec == '0) begin
					res_valid               = 1'b1;
					res.code_point          = shifted;
					state_next.partial_code = '0;
				end else begin
					state_next.partial_code = shifted;
				end
			end
		end
	end

endmodule

// ===== src/futd_obuf.sv =====
// ----------------------------------------------------------------------------
// futd_obuf
// Output register with a skid stage, so that stall is fully registered.
// ----------------------------------------------------------------------------
module futd_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  futd_pkg::result_t load_data,
	input  logic              out_stall,
	output logic              full,
	output logic              out_valid,
	output futd_pkg::result_t out_data
);

	logic              out_valid_q;
	futd_pkg::result_t out_data_q;
	logic              skid_valid_q;
	futd_pkg::result_t skid_data_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= load_valid;
			end
		end else if (load_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : load_data;
		end
		if (!out_free && load_valid) begin
			skid_data_q <= load_data;
		end
	end

endmodule

// ===== src/font_unicode_table_decoder.sv =====
// A result is registered in the output register, or in the skid stage while
// the output is stalled. Throughput: one byte per cycle while in_stall is low;
// the single decode stage and its state registers update on every accepted byte.
// in_stall rises only when both the output register and its skid stage hold
// results. Reset clears the decode state, the registers and both stages.
// ----------------------------------------------------------------------------
// font_unicode_table_decoder
// Decodes the UTF-8 runs of a bitmap font's Unicode table into
// (glyph index, code point) pairs.
// ----------------------------------------------------------------------------
module font_unicode_table_decoder #(
	parameter int INDEX_BITS = futd_pkg::DEF_INDEX_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [futd_pkg::BYTE_W-1:0]       in_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [futd_pkg::GLYPH_W-1:0]      glyph_index,
	output logic [futd_pkg::CODE_W-1:0]       code_point,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [futd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [futd_pkg::COUNT_W-1:0]      cfg_data
);

	logic [futd_pkg::COUNT_W-1:0] glyph_count_q;
	logic [futd_pkg::COUNT_W-1:0] index_base_q;
	futd_pkg::dec_state_t         state_q;
	futd_pkg::dec_state_t         state_next;
	logic                         res_valid;
	futd_pkg::result_t            res;
	futd_pkg::result_t            out_data;
	logic                         accept;
	logic                         skid_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_full;
	assign accept    = in_valid && !skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
			index_base_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				futd_pkg::REG_GLYPH_COUNT: glyph_count_q <= cfg_data;
				futd_pkg::REG_INDEX_BASE:  index_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	futd_step #(
		.INDEX_BITS(INDEX_BITS)
	) u_step (
		.state       (state_q),
		.in_byte     (in_byte),
		.glyph_count (glyph_count_q),
		.index_base  (index_base_q),
		.state_next  (state_next),
		.res_valid   (res_valid),
		.res         (res)
	);

	futd_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (accept && res_valid),
		.load_data  (res),
		.out_stall  (out_stall),
		.full       (skid_full),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

	assign glyph_index = out_data.glyph_index;
	assign code_point  = out_data.code_point;

endmodule

// ===== src/futd_checker.sv =====
// ----------------------------------------------------------------------------
// futd_checker
// Port-level checks for the font Unicode table decoder.
// ----------------------------------------------------------------------------
module futd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [futd_pkg::GLYPH_W-1:0]   glyph_index,
	input logic [futd_pkg::CODE_W-1:0]    code_point
);

	// Reset empties the output side.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// Input backpressure only arises with a result waiting at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("in_stall without a stalled transaction before it");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(glyph_index) &&
		$stable(code_point))
		else $error("stalled result changed or vanished");

endmodule

bind font_unicode_table_decoder futd_checker u_futd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.glyph_index (glyph_index),
	.code_point  (code_point)
);

// ===== sim/font_unicode_table_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_unicode_table_decoder_test
// Feeds Unicode table bytes to the decoder under random sender gaps and
// receiver stalls. A byte-level model of the table decoder predicts every
// (glyph index, code point) pair, and each delivered pair is checked in order.
// ----------------------------------------------------------------------------

class glyph_map_scoreboard;
	logic [futd_pkg::COUNT_W-1:0] glyph_count;
	logic [futd_pkg::COUNT_W-1:0] index_base;
	logic [futd_pkg::GLYPH_W-1:0] entry_number;
	logic [futd_pkg::CODE_W-1:0]  partial_code;
	logic [futd_pkg::LEFT_W-1:0]  bytes_left;
	futd_pkg::result_t            pending_mappings[$];
	int                           errors;

	function new();
		glyph_count  = '0;
		index_base   = '0;
		entry_number = '0;
		partial_code = '0;
		bytes_left   = '0;
		errors       = 0;
	endfunction

	function void set_register(logic [futd_pkg::CFG_IDX_W-1:0] index,
		logic [futd_pkg::COUNT_W-1:0] data);
		if (index == futd_pkg::REG_GLYPH_COUNT) begin
			glyph_count = data;
		end else if (index == futd_pkg::REG_INDEX_BASE) begin
			index_base = data;
		end
	endfunction

	function bit table_open();
		return entry_number < {1'b0, glyph_count};
	endfunction

	function void push_mapping(logic [futd_pkg::CODE_W-1:0] code);
		logic [63:0]       sum;
		futd_pkg::result_t r;
		sum = 64'(index_base) + 64'(entry_number);
		sum &= (64'd1 << (futd_pkg::DEF_INDEX_BITS + 1)) - 64'd1;
		r.glyph_index = sum[futd_pkg::GLYPH_W-1:0];
		r.code_point  = code;
		pending_mappings = {pending_mappings, r};
	endfunction

	function void close_entry();
		entry_number = entry_number + 1'b1;
		partial_code = '0;
		bytes_left   = '0;
	endfunction

	function logic [futd_pkg::CODE_W-1:0] CODE_CW(logic [futd_pkg::BYTE_W-1:0] value);
		return futd_pkg::CODE_W'(value);
	endfunction

	// Returns 1 when the byte was consumed by an open table.
	function bit decode_byte(logic [futd_pkg::BYTE_W-1:0] value);
		int ones;
		if (!table_open()) return 0;
		if (bytes_left == 0) begin
			if (value == futd_pkg::BYTE_ENTRY_END) begin
				close_entry();
			end else if (value < futd_pkg::LEAD_MIN || value == futd_pkg::BYTE_TILDE_SRC) begin
				push_mapping((value == futd_pkg::BYTE_TILDE_SRC) ?
					CODE_CW(futd_pkg::CODE_TILDE) : CODE_CW(value));
			end else begin
				// The number of leading ones gives the sequence length.
				ones = 0;
				while (ones < 8 && value[7 - ones]) ones++;
				bytes_left   = futd_pkg::LEFT_W'(ones - 1);
				partial_code = futd_pkg::CODE_W'(value & (8'hFF >> (ones + 1)));
			end
		end else if (value == futd_pkg::BYTE_ENTRY_END || value[7:6] != futd_pkg::CONT_TAG) begin
			close_entry();
		end else begin
			partial_code = {partial_code[futd_pkg::CODE_W-7:0], value[5:0]};
			bytes_left   = bytes_left - 1'b1;
			if (bytes_left == 0) begin
				push_mapping(partial_code);
				partial_code = '0;
			end
		end
		return 1;
	endfunction

	function void check_mapping(logic [futd_pkg::GLYPH_W-1:0] glyph,
		logic [futd_pkg::CODE_W-1:0] code);
		futd_pkg::result_t want;
		if (pending_mappings.size() == 0) begin
			$display("%0t: unexpected transaction, glyph_index %0d code_point 0x%0h",
				$time, glyph, code);
			errors++;
			return;
		end
		want = pending_mappings.pop_front();
		if (want.glyph_index !== glyph) begin
			$display("%0t: glyph_index expected %0d, actual %0d", $time, want.glyph_index, glyph);
			errors++;
		end
		if (want.code_point !== code) begin
			$display("%0t: code_point expected 0x%0h, actual 0x%0h",
				$time, want.code_point, code);
			errors++;
		end
	endfunction
endclass

module font_unicode_table_decoder_test;

	localparam logic [futd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [futd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int HOLD_CYCLES = 300;

	// Four entries touching the ASCII and tilde cases, every lead class, both kinds of
	// bad continuation, the largest code point, then one byte after the table is done.
	localparam logic [futd_pkg::BYTE_W-1:0] OPENING_TABLE [27] = '{
		8'h00, 8'hFE, 8'hC0, 8'h80, 8'hFF,
		8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hE2, 8'hC1,
		8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hFF,
		8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF,
		8'h41
	};

	typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [futd_pkg::BYTE_W-1:0]    in_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic [futd_pkg::GLYPH_W-1:0]   glyph_index;
	logic [futd_pkg::CODE_W-1:0]    code_point;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [futd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [futd_pkg::COUNT_W-1:0]   cfg_data;

	glyph_map_scoreboard tracker = new();
	int burst_left = 0;
	int bytes_sent = 0;
	bit hold_request = 0;

	font_unicode_table_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.glyph_index(glyph_index),
		.code_point(code_point),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("font_unicode_table_decoder regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_mapping(glyph_index, code_point);
	end

	// Result side: stretches of different stall behavior, plus a long hold on request.
	initial begin : result_sink
		sink_mode_t mode;
		int run_left;
		mode = SINK_OPEN;
		run_left = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					run_left = $urandom_range(8, 120);
				end
				run_left--;
				case (mode)
					SINK_OPEN: out_stall <= 1'b0;
					SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	task automatic send_byte(input logic [futd_pkg::BYTE_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_byte  <= value;
		do @(posedge clk); while (in_stall);
		if (tracker.decode_byte(value)) bytes_sent++;
		burst_left--;
	endtask

	// Stops offering bytes and waits until every predicted pair has been delivered.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending_mappings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [futd_pkg::CFG_IDX_W-1:0] index,
		input logic [futd_pkg::COUNT_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_register(index, data);
	endtask

	// Mostly well-formed entries with random content; the rest are broken entries
	// and loose noise bytes. Stops early once the table is finished.
	task automatic run_random(input int count);
		int stop_at;
		int seqs;
		int len;
		int kind;
		bit broken;
		logic [futd_pkg::BYTE_W-1:0] bad;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at && tracker.table_open()) begin
			if ($urandom_range(0, 9) < 8) begin
				seqs = $urandom_range(0, 4);
				broken = ($urandom_range(0, 6) == 0);
				for (int s = 0; s < seqs + broken; s++) begin
					kind = $urandom_range(0, 9);
					if (kind < 4 && !(broken && s == seqs)) begin
						send_byte(futd_pkg::BYTE_W'($urandom_range(0, 8'hBF)));
					end else if (kind == 4 && !(broken && s == seqs)) begin
						send_byte(futd_pkg::BYTE_TILDE_SRC);
					end else begin
						len = $urandom_range(2, 6);
						send_byte(futd_pkg::BYTE_W'((8'hFF << (8 - len)) |
							($urandom & (8'hFF >> (len + 1)))));
						if (broken && s == seqs) begin
							repeat ($urandom_range(0, len - 2))
								send_byte({futd_pkg::CONT_TAG, 6'($urandom)});
							do bad = futd_pkg::BYTE_W'($urandom);
							while (bad[7:6] == futd_pkg::CONT_TAG);
							send_byte(bad);
						end else begin
							repeat (len - 1) send_byte({futd_pkg::CONT_TAG, 6'($urandom)});
						end
					end
				end
				if (!broken) send_byte(futd_pkg::BYTE_ENTRY_END);
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(futd_pkg::BYTE_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(futd_pkg::REG_GLYPH_COUNT, 16'd4);
		write_reg(futd_pkg::REG_INDEX_BASE, 16'hFFFF);
		foreach (OPENING_TABLE[i]) send_byte(OPENING_TABLE[i]);

		write_reg(futd_pkg::REG_GLYPH_COUNT, 16'hFFFF);
		write_reg(futd_pkg::REG_INDEX_BASE, 16'h0000);
		run_random(200);
		// The sink holds off while bytes keep coming, so the block backs up.
		hold_request = 1;
		run_random(150);
		settle();
		run_random(150);

		// Lowering the count to the entries already done closes the table.
		write_reg(futd_pkg::REG_GLYPH_COUNT, futd_pkg::COUNT_W'(tracker.entry_number));
		write_reg(REG_SPARE_A, futd_pkg::COUNT_W'($urandom));
		write_reg(REG_SPARE_B, futd_pkg::COUNT_W'($urandom));
		repeat (16) send_byte(futd_pkg::BYTE_W'($urandom));
		write_reg(futd_pkg::REG_GLYPH_COUNT, 16'd0);
		repeat (8) send_byte(futd_pkg::BYTE_W'($urandom));

		write_reg(futd_pkg::REG_GLYPH_COUNT, futd_pkg::COUNT_W'(tracker.entry_number + 60));
		write_reg(futd_pkg::REG_INDEX_BASE, futd_pkg::COUNT_W'($urandom));
		run_random(400);
		repeat (8) send_byte(futd_pkg::BYTE_W'($urandom));

		write_reg(futd_pkg::REG_GLYPH_COUNT,
			futd_pkg::COUNT_W'($urandom_range(tracker.entry_number + 200, 16'hFFFF)));
		write_reg(futd_pkg::REG_INDEX_BASE, futd_pkg::COUNT_W'($urandom));
		hold_request = 1;
		run_random(500);

		write_reg(futd_pkg::REG_GLYPH_COUNT, 16'hFFFF);
		write_reg(futd_pkg::REG_INDEX_BASE,
			futd_pkg::COUNT_W'($urandom_range(16'hF000, 16'hFFFF)));
		run_random(300);

		settle();
		if (tracker.errors == 0 && tracker.pending_mappings.size() == 0) begin
			$display("font_unicode_table_decoder regression: pass");
		end else begin
			$display("font_unicode_table_decoder regression: fail");
		end
		$finish;
	end

endmodule

// ===== font_unicode_table_decoder.f =====
src/futd_pkg.sv
src/futd_step.sv
src/futd_obuf.sv
src/font_unicode_table_decoder.sv
src/futd_checker.sv
sim/font_unicode_table_decoder_test.sv
